FILE: design/gyi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyi_pkg
// Shared types and constants for the gyro yaw integrator: opcodes, register
// map, fixed-point constants, the CORDIC arctangent table and the
// controller/datapath interface.
// ----------------------------------------------------------------------------
package gyi_pkg;

    // Operation carried in the input beat's tuser bit.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Register map (register index, i.e. byte address / 4).
    localparam logic REG_STEP_PERIOD = 1'b0;
    localparam logic [15:0] STEP_PERIOD_RESET = 16'd6554;

    // 4/pi in Q1.30 and the CORDIC start value (inverse gain) in Q2.30.
    localparam logic [30:0] FOUR_OVER_PI_Q30 = 31'd1367130551;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Half-angle quadrant limits, 2^32 = 2*pi.
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    localparam logic signed [17:0] Q14_MAX = 18'sd16384;
    localparam logic signed [17:0] Q14_MIN = -18'sd16384;

    localparam logic [1:0] LAST_AXIS = 2'd2;

    // Arctangent of 2^-i in 2^32 = 2*pi units.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MULP  = 7'b0000010,
        ST_MULK  = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_CINIT = 7'b0010000,
        ST_CSTEP = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic sample_load;
        logic mul_p;
        logic mul_k;
        logic acc_step;
        logic cordic_init;
        logic cordic_step;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_last;
    } dp_status_t;

endpackage

FILE: design/gyi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyi_ctrl
// Sequencer for the integrator: walks the three axes through the shared
// multiplier, runs the CORDIC and hands the result to the output register.
// ----------------------------------------------------------------------------
module gyi_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_op,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  gyi_pkg::dp_status_t status,
    output gyi_pkg::dp_cmd_t    cmd
);

    gyi_pkg::state_t state_reg, state_next;
    logic [1:0]      axis_reg, axis_next;
    logic            out_valid_reg, out_valid_next;
    logic            in_fire;
    logic            out_free;

    assign in_ready  = (state_reg == gyi_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gyi_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == gyi_pkg::OP_TICK)
                    begin
                        axis_next  = 2'd0;
                        state_next = gyi_pkg::ST_MULP;
                    end
                    else
                    begin
                        cmd.sample_load = 1'b1;
                    end
                end
            end
            gyi_pkg::ST_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = gyi_pkg::ST_MULK;
            end
            gyi_pkg::ST_MULK:
            begin
                cmd.mul_k  = 1'b1;
                state_next = gyi_pkg::ST_ACC;
            end
            gyi_pkg::ST_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (axis_reg == gyi_pkg::LAST_AXIS)
                begin
                    state_next = gyi_pkg::ST_CINIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = gyi_pkg::ST_MULP;
                end
            end
            gyi_pkg::ST_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = gyi_pkg::ST_CSTEP;
            end
            gyi_pkg::ST_CSTEP:
            begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_last)
                begin
                    state_next = gyi_pkg::ST_DONE;
                end
            end
            gyi_pkg::ST_DONE:
            begin
                // Hold the finished result until the output register is free.
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = gyi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gyi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gyi_pkg::ST_IDLE;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/gyi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyi_datapath
// Held rates, the three angle accumulators, the shared rate*dt*(4/pi)
// multiplier, the iterative CORDIC and the output register.
// ----------------------------------------------------------------------------
module gyi_datapath #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gyi_pkg::dp_cmd_t    cmd,
    output gyi_pkg::dp_status_t status,
    input  logic [15:0]         step_period,
    input  logic [47:0]         in_data,
    output logic [175:0]        out_data
);

    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam int SH     = 62 - ANGLE_BITS;
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (SH - 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    // Index 0 is the axis under work; the rings rotate once per axis, so
    // after three steps roll, pitch and yaw are back in places 0, 1 and 2.
    logic [15:0]            rate_reg [0:2];
    logic [ANGLE_BITS-1:0]  acc_reg  [0:2];
    logic [31:0]            ang32    [0:2];

    logic signed [31:0]     p_reg;
    logic signed [62:0]     p_ext, k_ext;
    logic signed [62:0]     prod_reg;
    logic signed [63:0]     rnd_sum;
    logic signed [63:0]     rnd_shift;
    logic [ANGLE_BITS-1:0]  delta;

    logic signed [33:0]     x_reg, y_reg, z_reg;
    logic                   flip_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic signed [33:0]     dx, dy, atan_ext;
    logic signed [33:0]     theta;

    logic [15:0]            quat_z_reg, quat_w_reg;
    logic [15:0]            orate_reg [0:2];
    logic [31:0]            oang_reg  [0:2];

    function automatic logic [15:0] to_q14(input logic signed [33:0] v, input logic neg);
        logic signed [34:0] t;
        logic signed [17:0] r;
        t = {v[33], v} + 35'sd32768;
        r = 18'(t >>> 16);
        if (neg)
        begin
            r = -r;
        end
        if (r > gyi_pkg::Q14_MAX)
        begin
            r = gyi_pkg::Q14_MAX;
        end
        if (r < gyi_pkg::Q14_MIN)
        begin
            r = gyi_pkg::Q14_MIN;
        end
        return r[15:0];
    endfunction

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_align
            if (ANGLE_BITS >= 32)
            begin : g_top
                assign ang32[g] = acc_reg[g][ANGLE_BITS-1 -: 32];
            end
            else
            begin : g_pad
                assign ang32[g] = {acc_reg[g], {(32 - ANGLE_BITS){1'b0}}};
            end
        end
    endgenerate

    // Round to nearest, ties away from zero: floor((p + h - [p<0]) / 2^SH).
    assign rnd_sum   = {prod_reg[62], prod_reg} + RND_HALF - {63'd0, prod_reg[62]};
    assign rnd_shift = rnd_sum >>> SH;
    assign delta     = rnd_shift[ANGLE_BITS-1:0];

    // The product needs the full 63 bits, so both operands are widened first.
    assign p_ext = 63'(p_reg);
    assign k_ext = 63'($signed({1'b0, gyi_pkg::FOUR_OVER_PI_Q30}));

    assign dx       = y_reg >>> iter_reg;
    assign dy       = x_reg >>> iter_reg;
    assign atan_ext = {2'b00, gyi_pkg::atan_entry(5'(iter_reg))};
    assign theta    = {{2{ang32[2][31]}}, ang32[2]};

    assign status.cordic_last = (iter_reg == ITER_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rate_reg[k] <= '0;
                acc_reg[k]  <= '0;
            end
        end
        else if (cmd.sample_load)
        begin
            rate_reg[0] <= in_data[15:0];
            rate_reg[1] <= in_data[31:16];
            rate_reg[2] <= in_data[47:32];
        end
        else if (cmd.acc_step)
        begin
            rate_reg[0] <= rate_reg[1];
            rate_reg[1] <= rate_reg[2];
            rate_reg[2] <= rate_reg[0];
            acc_reg[0]  <= acc_reg[1];
            acc_reg[1]  <= acc_reg[2];
            acc_reg[2]  <= acc_reg[0] + delta;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_p)
        begin
            p_reg <= 32'($signed(rate_reg[0])) * 32'($signed({1'b0, step_period}));
        end
        if (cmd.mul_k)
        begin
            prod_reg <= p_ext * k_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (cmd.cordic_init)
        begin
            iter_reg <= '0;
        end
        else if (cmd.cordic_step && !status.cordic_last)
        begin
            iter_reg <= iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            x_reg <= gyi_pkg::CORDIC_GAIN_Q30;
            y_reg <= '0;
            // Half angles beyond a quarter turn are turned by pi and the
            // results negated at the end.
            if (theta > gyi_pkg::QUARTER_TURN)
            begin
                z_reg    <= theta - gyi_pkg::HALF_TURN;
                flip_reg <= 1'b1;
            end
            else if (theta < -gyi_pkg::QUARTER_TURN)
            begin
                z_reg    <= theta + gyi_pkg::HALF_TURN;
                flip_reg <= 1'b1;
            end
            else
            begin
                z_reg    <= theta;
                flip_reg <= 1'b0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            quat_z_reg <= to_q14(y_reg, flip_reg);
            quat_w_reg <= to_q14(x_reg, flip_reg);
            for (int k = 0; k < 3; k++)
            begin
                orate_reg[k] <= rate_reg[k];
                oang_reg[k]  <= ang32[k];
            end
        end
    end

    assign out_data = {oang_reg[2], oang_reg[1], oang_reg[0],
                       orate_reg[2], orate_reg[1], orate_reg[0],
                       quat_w_reg, quat_z_reg};

endmodule

FILE: design/gyro_yaw_integrator_quaternion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_yaw_integrator_quaternion_top
// Gyro rate integrator with a yaw-only quaternion output.
// ----------------------------------------------------------------------------
// A sample beat (tuser 0) latches three Q4.12 body rates and gives no
// output. A tick beat (tuser 1) adds rate*dt to the roll, pitch and
// yaw binary angles (2^32 = 4*pi) and emits sin and cos of half the yaw in
// Q1.14 together with the held rates and the three angles. A tick occupies
// the block until its result is loaded: one shared multiplier serves the
// three axes in turn, and the CORDIC resolves one iteration per cycle.
// The result sits in an output register, so samples are still taken while
// it waits; a following tick waits at its end for that register to drain.
// The only register, step_period at address 0, is written over the APB
// port.
// ----------------------------------------------------------------------------
module gyro_yaw_integrator_quaternion_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // rate_x, rate_y, rate_z
    input  logic         s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata,   // quat_z, quat_w, out_rate_x, out_rate_y,
                                         // out_rate_z, roll_angle, pitch_angle,
                                         // yaw_angle
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0]         step_period_reg;
    logic                reg_sel;
    gyi_pkg::dp_cmd_t    cmd;
    gyi_pkg::dp_status_t status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == gyi_pkg::REG_STEP_PERIOD);
    assign prdata  = reg_sel ? {16'd0, step_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg <= gyi_pkg::STEP_PERIOD_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            step_period_reg <= pwdata[15:0];
        end
    end

    gyi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    gyi_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .step_period (step_period_reg),
        .in_data     (s_axis_tdata),
        .out_data    (m_axis_tdata)
    );

endmodule

FILE: design/gyi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyi_checker
// Port-level checks for the gyro yaw integrator, bound to the top level.
// ----------------------------------------------------------------------------
module gyi_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata
);

    // A waiting result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat withdrawn before it was taken");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // A tick makes the block busy on the next cycle.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == gyi_pkg::OP_TICK)
        |=> !s_axis_tready)
        else $error("block still ready after taking a tick");

    // A sample is latched and leaves the block ready.
    a_sample_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == gyi_pkg::OP_SAMPLE)
        |=> s_axis_tready)
        else $error("block busy after a sample beat");

    // A new result appears only as the block returns to ready.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result offered while the block is busy");

endmodule

bind gyro_yaw_integrator_quaternion_top gyi_checker u_gyi_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gyro yaw integrator. Sample and tick beats are
// driven with random gaps and the output stream is stalled at random. An
// attitude tracker works out the angles and the half-yaw sine and cosine for
// every tick and compares each output beat with them field by field. The
// integration period is rewritten between phases, over the APB port, while
// the block is idle. The period is read back after each phase's writes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  PHASES       = 9;
    localparam int  BEATS_PER_PHASE = 110;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  STALL_LIMIT  = 2000;
    localparam logic [2:0] STEP_PERIOD_ADDR = 3'(gyi_pkg::REG_STEP_PERIOD) << 2;
    localparam logic [2:0] SPARE_ADDR       = 3'd4;

    // Arctangent of 2^-i, with 2^32 standing for a full turn.
    localparam longint ARC_STEP [0:15] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct {
        logic [15:0] quat_z;
        logic [15:0] quat_w;
        logic [15:0] rate_x;
        logic [15:0] rate_y;
        logic [15:0] rate_z;
        logic [31:0] roll;
        logic [31:0] pitch;
        logic [31:0] yaw;
    } attitude_t;

    class attitude_tracker;
        logic [15:0] period;
        logic [15:0] held_x, held_y, held_z;
        logic [31:0] roll_acc, pitch_acc, yaw_acc;
        attitude_t   awaited[$];
        int          errors;

        function new();
            period    = gyi_pkg::STEP_PERIOD_RESET;
            held_x    = '0;
            held_y    = '0;
            held_z    = '0;
            roll_acc  = '0;
            pitch_acc = '0;
            yaw_acc   = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] value);
            if ((addr >> 2) == 3'(gyi_pkg::REG_STEP_PERIOD))
                period = value[15:0];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Adds round(rate * dt * 4/pi) to a binary angle, ties away from zero.
        function logic [31:0] advance(logic [31:0] acc, logic [15:0] rate);
            longint prod, mag, step;
            prod = longint'($signed(rate)) * longint'(period) * 64'sd1367130551;
            mag  = (prod < 0) ? -prod : prod;
            step = (mag + (64'sd1 <<< 29)) >>> 30;
            if (prod < 0)
                step = -step;
            return acc + step[31:0];
        endfunction

        function logic [15:0] to_q14(longint v, bit flip);
            longint r;
            r = (v + 32768) >>> 16;
            if (flip)
                r = -r;
            if (r > 16384)
                r = 16384;
            if (r < -16384)
                r = -16384;
            return r[15:0];
        endfunction

        function void half_sincos(logic [31:0] theta, output logic [15:0] s,
                                  output logic [15:0] c);
            longint z, x, y, dx, dy;
            bit     flip;
            z    = longint'($signed(theta));
            x    = 64'sd652032874;
            y    = 0;
            flip = 1'b0;
            // Outside a quarter turn either way, rotate by half a turn and negate.
            if (z > 64'sd1073741824)
            begin
                z    = z - 64'sd2147483648;
                flip = 1'b1;
            end
            else if (z < -64'sd1073741824)
            begin
                z    = z + 64'sd2147483648;
                flip = 1'b1;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARC_STEP[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARC_STEP[i];
                end
            end
            s = to_q14(y, flip);
            c = to_q14(x, flip);
        endfunction

        function void note_beat(logic op, logic [47:0] data);
            attitude_t a;
            if (op == gyi_pkg::OP_SAMPLE)
            begin
                held_x = data[15:0];
                held_y = data[31:16];
                held_z = data[47:32];
            end
            else
            begin
                roll_acc  = advance(roll_acc, held_x);
                pitch_acc = advance(pitch_acc, held_y);
                yaw_acc   = advance(yaw_acc, held_z);
                half_sincos(yaw_acc, a.quat_z, a.quat_w);
                a.rate_x = held_x;
                a.rate_y = held_y;
                a.rate_z = held_z;
                a.roll   = roll_acc;
                a.pitch  = pitch_acc;
                a.yaw    = yaw_acc;
                awaited.push_back(a);
            end
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [175:0] d);
            attitude_t a;
            if (awaited.size() == 0)
            begin
                $error("output beat 0x%044h with no tick outstanding", d);
                errors++;
            end
            else
            begin
                a = awaited.pop_front();
                compare("quat_z", 32'(a.quat_z), 32'(d[15:0]));
                compare("quat_w", 32'(a.quat_w), 32'(d[31:16]));
                compare("out_rate_x", 32'(a.rate_x), 32'(d[47:32]));
                compare("out_rate_y", 32'(a.rate_y), 32'(d[63:48]));
                compare("out_rate_z", 32'(a.rate_z), 32'(d[79:64]));
                compare("roll_angle", a.roll, d[111:80]);
                compare("pitch_angle", a.pitch, d[143:112]);
                compare("yaw_angle", a.yaw, d[175:144]);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [175:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    attitude_tracker tracker;
    bit              send_quiet;
    bit              recv_quiet;
    int              idle_cycles;

    gyro_yaw_integrator_quaternion_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drives one beat after a random gap; tvalid is left high for the next one.
    task automatic send_beat(input logic op, input logic [47:0] data);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = data;
        do @(posedge clk); while (!s_axis_tready);
        tracker.note_beat(op, data);
    endtask

    task automatic sample_beat(input logic [15:0] rx, input logic [15:0] ry,
                               input logic [15:0] rz);
        send_beat(gyi_pkg::OP_SAMPLE, {rz, ry, rx});
    endtask

    // The rates of a tick beat are ignored, so they carry random noise.
    task automatic tick_beat();
        send_beat(gyi_pkg::OP_TICK, 48'({$urandom(), $urandom()}));
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_reg(addr, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_period_readback();
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = STEP_PERIOD_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== tracker.period)
        begin
            $error("step_period readback: expected 0x%04h, got 0x%04h",
                   tracker.period, prdata[15:0]);
            tracker.errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_rate(output logic [15:0] r);
        case ($urandom_range(0, 3))
            0:       r = 16'($signed($urandom_range(0, 1023)) - 512);
            1:       r = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: r = 16'($urandom());
        endcase
    endtask

    task automatic random_beats(input int count);
        logic [15:0] rx, ry, rz;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1) != 0)
                tick_beat();
            else
            begin
                random_rate(rx);
                random_rate(ry);
                random_rate(rz);
                sample_beat(rx, ry, rz);
            end
        end
    endtask

    task automatic directed_beats();
        tick_beat();                       // no sample yet: rates are zero
        sample_beat(16'h7FFF, 16'h8000, 16'h0000);
        tick_beat();
        tick_beat();
        sample_beat(16'h8000, 16'h7FFF, 16'hFFFF);
        tick_beat();
        tick_beat();
        sample_beat(16'h5555, 16'hAAAA, 16'h0001);
        tick_beat();
        sample_beat(16'hAAAA, 16'h5555, 16'h7FFF);
        repeat (4) tick_beat();
        sample_beat(16'h0000, 16'h0000, 16'h8000);
        repeat (3) tick_beat();
        sample_beat(16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick_beat();
        sample_beat(16'h0000, 16'h0000, 16'h0000);
        tick_beat();
    endtask

    // Output side: a random stall before each beat.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_quiet ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            tracker.check_beat(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                 || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        tracker       = new();
        send_quiet    = 1'b0;
        recv_quiet    = 1'b0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = gyi_pkg::OP_SAMPLE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                case (phase)
                    1:       apb_write(STEP_PERIOD_ADDR, 32'h0000_FFFF);
                    2:       apb_write(STEP_PERIOD_ADDR, 32'h0000_0001);
                    3:       apb_write(STEP_PERIOD_ADDR, 32'h0000_0000);
                    4:
                    begin
                        apb_write(STEP_PERIOD_ADDR, $urandom_range(1, 65535));
                        apb_write(SPARE_ADDR, $urandom());
                    end
                    // Bits above the register width must be dropped.
                    6:       apb_write(STEP_PERIOD_ADDR,
                                       {16'hFFFF, 16'($urandom_range(1, 65535))});
                    default: apb_write(STEP_PERIOD_ADDR, $urandom_range(1, 65535));
                endcase
                check_period_readback();
            end
            send_quiet = (phase == 2) || (phase == 6);
            recv_quiet = (phase == 5) || (phase == 6);
            if (phase == 0)
                directed_beats();
            random_beats(BEATS_PER_PHASE);
        end
        drain();

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
design/gyi_pkg.sv
design/gyi_ctrl.sv
design/gyi_datapath.sv
design/gyro_yaw_integrator_quaternion_top.sv
design/gyi_checker.sv
bench/testbench.sv
